/* design/timer_divider_with_reload_irq_assert.svh */
// Assertion macros shared by the timer RTL files.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TIMER_DIVIDER_WITH_RELOAD_IRQ_ASSERT_SVH
`define TIMER_DIVIDER_WITH_RELOAD_IRQ_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TDR_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("timer assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TDR_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("timer assertion failed: next-cycle implication");

`endif

/* design/tdr_pkg.sv */
// Types, codes and helper functions of the timer with divider and reload.
// Depends on nothing; used by every module of the block.
package tdr_pkg;

   // Operation codes of an input word.
   localparam logic [1:0] FUNC_ADVANCE = 2'd0;
   localparam logic [1:0] FUNC_READ    = 2'd1;
   localparam logic [1:0] FUNC_WRITE   = 2'd2;

   // Timer register selects.
   localparam logic [1:0] REG_DIVIDER = 2'd0;
   localparam logic [1:0] REG_COUNTER = 2'd1;
   localparam logic [1:0] REG_MODULO  = 2'd2;
   localparam logic [1:0] REG_CONTROL = 2'd3;

   // Configuration register indexes (byte address bit 2).
   localparam logic CSR_TICK_PERIOD = 1'b0;
   localparam logic CSR_DIV_PERIOD  = 1'b1;

   localparam logic [11:0] TICK_PERIOD_RESET = 12'd286;
   localparam logic [19:0] DIV_PERIOD_RESET  = 20'd73216;

   localparam logic [7:0] COUNT_WRAP     = 8'hFF;
   localparam int unsigned CTRL_ENABLE_BIT = 2;

   typedef struct packed {
      logic [1:0]  func;
      logic [1:0]  reg_sel;
      logic [7:0]  write_data;
      logic [15:0] elapsed;
      logic        irq_blocked;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_request;
   } rsp_type;

   typedef struct packed {
      logic [11:0] tick_period;
      logic [19:0] div_period;
   } cfg_type;

   // Timer period for a control write: tick period times 1024, 16, 64 or 256.
   function automatic logic [21:0] timer_period_of(input logic [11:0] tick,
                                                   input logic [1:0]  rate);
      logic [21:0] base;
      base = {10'd0, tick};
      case (rate)
         2'd0:    timer_period_of = base << 10;
         2'd1:    timer_period_of = base << 4;
         2'd2:    timer_period_of = base << 6;
         2'd3:    timer_period_of = base << 8;
         default: timer_period_of = base << 10;
      endcase
   endfunction

endpackage

/* design/tdr_countdown.sv */
// One down-counter step: subtract elapsed time, add one period back on
// underflow and saturate to 24-bit signed range. Depends on tdr_pkg.
module tdr_countdown
   import tdr_pkg::*;
(
   input  logic signed [23:0] remaining,
   input  logic        [15:0] elapsed,
   input  logic        [21:0] period,
   output logic signed [23:0] remaining_next,
   output logic               wrapped
);

   logic signed [25:0] diff;
   logic signed [25:0] sum;

   always_comb begin
      diff    = {{2{remaining[23]}}, remaining} - $signed({10'd0, elapsed});
      wrapped = diff[25];
      sum     = wrapped ? diff + $signed({4'd0, period}) : diff;
      if (sum[25:23] == 3'b000 || sum[25:23] == 3'b111) begin
         remaining_next = sum[23:0];
      end else if (sum[25]) begin
         remaining_next = {1'b1, 23'd0};
      end else begin
         remaining_next = {1'b0, {23{1'b1}}};
      end
   end

endmodule

/* design/tdr_core.sv */
// Timer state and its next-state logic for one word per cycle in which step is high.
// Depends on tdr_pkg, tdr_countdown and the assertion macro header.
`include "timer_divider_with_reload_irq_assert.svh"

module tdr_core
   import tdr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   logic [7:0]         divider_byte_ff, divider_byte_in;
   logic signed [23:0] divider_rem_ff, divider_rem_in;
   logic [7:0]         count_byte_ff, count_byte_in;
   logic [7:0]         modulo_byte_ff, modulo_byte_in;
   logic [7:0]         control_byte_ff, control_byte_in;
   logic [21:0]        timer_period_ff, timer_period_in;
   logic               timer_enabled_ff, timer_enabled_in;
   logic signed [23:0] timer_rem_ff, timer_rem_in;
   logic               irq_pending_ff, irq_pending_in;

   logic signed [23:0] div_rem_next, tmr_rem_next;
   logic               div_wrap, tmr_wrap;

   tdr_countdown u_div_cd (
      .remaining      (divider_rem_ff),
      .elapsed        (item.elapsed),
      .period         ({2'd0, cfg.div_period}),
      .remaining_next (div_rem_next),
      .wrapped        (div_wrap)
   );

   tdr_countdown u_tmr_cd (
      .remaining      (timer_rem_ff),
      .elapsed        (item.elapsed),
      .period         (timer_period_ff),
      .remaining_next (tmr_rem_next),
      .wrapped        (tmr_wrap)
   );

   always_comb begin
      logic pending;
      divider_byte_in  = divider_byte_ff;
      divider_rem_in   = divider_rem_ff;
      count_byte_in    = count_byte_ff;
      modulo_byte_in   = modulo_byte_ff;
      control_byte_in  = control_byte_ff;
      timer_period_in  = timer_period_ff;
      timer_enabled_in = timer_enabled_ff;
      timer_rem_in     = timer_rem_ff;
      pending          = irq_pending_ff;
      irq_pending_in   = irq_pending_ff;
      result           = '0;
      case (item.func)
         FUNC_ADVANCE: begin
            if (cfg.div_period != 20'd0) begin
               divider_rem_in = div_rem_next;
               if (div_wrap) begin
                  divider_byte_in = divider_byte_ff + 8'd1;
               end
            end
            if (timer_enabled_ff && timer_period_ff != 22'd0) begin
               timer_rem_in = tmr_rem_next;
               if (tmr_wrap) begin
                  if (count_byte_ff == COUNT_WRAP) begin
                     count_byte_in = modulo_byte_ff;
                     pending       = 1'b1;
                  end else begin
                     count_byte_in = count_byte_ff + 8'd1;
                  end
               end
            end
            if (!item.irq_blocked && pending) begin
               pending            = 1'b0;
               result.irq_request = 1'b1;
            end
            irq_pending_in = pending;
         end
         FUNC_READ: begin
            case (item.reg_sel)
               REG_DIVIDER: result.read_data = divider_byte_ff;
               REG_COUNTER: result.read_data = count_byte_ff;
               REG_MODULO:  result.read_data = modulo_byte_ff;
               default:     result.read_data = control_byte_ff;
            endcase
         end
         FUNC_WRITE: begin
            case (item.reg_sel)
               REG_DIVIDER: divider_byte_in = 8'd0;
               REG_COUNTER: count_byte_in   = item.write_data;
               REG_MODULO:  modulo_byte_in  = item.write_data;
               default: begin
                  control_byte_in  = item.write_data;
                  timer_period_in  = timer_period_of(cfg.tick_period,
                                                     item.write_data[1:0]);
                  timer_enabled_in = item.write_data[CTRL_ENABLE_BIT];
               end
            endcase
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_byte_ff  <= '0;
         divider_rem_ff   <= '0;
         count_byte_ff    <= '0;
         modulo_byte_ff   <= '0;
         control_byte_ff  <= '0;
         timer_period_ff  <= '0;
         timer_enabled_ff <= 1'b0;
         timer_rem_ff     <= '0;
         irq_pending_ff   <= 1'b0;
      end else if (step) begin
         divider_byte_ff  <= divider_byte_in;
         divider_rem_ff   <= divider_rem_in;
         count_byte_ff    <= count_byte_in;
         modulo_byte_ff   <= modulo_byte_in;
         control_byte_ff  <= control_byte_in;
         timer_period_ff  <= timer_period_in;
         timer_enabled_ff <= timer_enabled_in;
         timer_rem_ff     <= timer_rem_in;
         irq_pending_ff   <= irq_pending_in;
      end
   end

   // A divider write always leaves the divider byte at zero.
   `TDR_ASSERT_NXT(a_div_clear, clock, reset,
      step && item.func == FUNC_WRITE && item.reg_sel == REG_DIVIDER,
      divider_byte_ff == 8'd0)
   // A delivered request is no longer pending afterwards.
   `TDR_ASSERT_NXT(a_irq_clear, clock, reset,
      step && result.irq_request, !irq_pending_ff)
   // A stopped timer never moves its down-counter.
   `TDR_ASSERT_NXT(a_tmr_hold, clock, reset,
      !timer_enabled_ff, $stable(timer_rem_ff))

endmodule

/* design/timer_divider_with_reload_irq.sv */
// Timer with free-running divider, reload counter and interrupt request:
// each word on the req_ channel is a time advance, a timer register read or a
// timer register write, and produces exactly one word on the rsp_ channel. The
// block takes one word per clock cycle when the result side keeps up. A word
// is captured in an input register and processed, once the result register is
// free or being emptied, by a single pass of subtract, add-back and saturate
// logic. Its result is loaded into the result register at the end of that
// cycle, which raises rsp_valid. The input register and the result register
// each hold one word; when the result is not taken, processing stops and the
// input register fills, after which req_ready drops. The APB-style port holds
// the tick period (address 0) and the divider period (address 4); write them
// only while no word is in flight.
// Depends on tdr_pkg, tdr_core and the assertion macro header.
`include "timer_divider_with_reload_irq_assert.svh"

module timer_divider_with_reload_irq
   import tdr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Configuration registers.
   logic [11:0] tick_period_ff;
   logic [19:0] div_period_ff;
   cfg_type     cfg;

   // Input register: one word waiting to be processed.
   req_type     in_word_ff;
   logic        in_valid_ff;

   // Result register: one finished word waiting to be taken.
   rsp_type     out_word_ff;
   logic        out_valid_ff;

   rsp_type     core_result;
   logic        step;
   logic        req_fire;
   logic        csr_write;

   // The word in the input register is processed whenever the result
   // register is empty or is being emptied in this same cycle.
   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign req_fire  = req_valid && req_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_word_ff <= req_data;
      end
      if (step) begin
         out_word_ff <= core_result;
      end
   end

   assign cfg.tick_period = tick_period_ff;
   assign cfg.div_period  = div_period_ff;

   tdr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_word_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   // Configuration port: zero wait states, register picked by address bit 2.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff <= TICK_PERIOD_RESET;
         div_period_ff  <= DIV_PERIOD_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            CSR_TICK_PERIOD: tick_period_ff <= pwdata[11:0];
            CSR_DIV_PERIOD:  div_period_ff  <= pwdata[19:0];
            default:         tick_period_ff <= tick_period_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_TICK_PERIOD: prdata = {20'd0, tick_period_ff};
         CSR_DIV_PERIOD:  prdata = {12'd0, div_period_ff};
         default:         prdata = '0;
      endcase
   end

   // An accepted word always lands in the input register.
   `TDR_ASSERT_NXT(a_in_load, clock, reset, req_fire, in_valid_ff)
   // Processing a word always fills the result register.
   `TDR_ASSERT_NXT(a_out_load, clock, reset, step, out_valid_ff)
   // A word never carries both read data and an interrupt request.
   `TDR_ASSERT_IMP(a_rsp_excl, clock, reset,
      rsp_valid && rsp_data.irq_request, rsp_data.read_data == 8'd0)

endmodule

/* sim/timer_divider_with_reload_irq_tb.sv */
// Self-checking testbench for the timer with divider, reload counter and interrupt request.
// Depends on tdr_pkg and the timer_divider_with_reload_irq RTL; reads no files at run time.
`timescale 1ns / 100ps

module timer_divider_with_reload_irq_tb
   import tdr_pkg::*;
();

   // The package names three operation codes; the fourth does nothing but still answers.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // Byte addresses of the two configuration registers.
   localparam logic [2:0] ADDR_TICK_PERIOD = {CSR_TICK_PERIOD, 2'b00};
   localparam logic [2:0] ADDR_DIV_PERIOD  = {CSR_DIV_PERIOD, 2'b00};

   // The 24-bit signed down-counters clamp to this range.
   localparam int COUNT_FLOOR = -8388608;
   localparam int COUNT_CEIL  = 8388607;

   localparam int ITEMS_PER_PHASE = 175;
   localparam int CYCLE_LIMIT     = 600000;

   // This class keeps a shadow copy of the timer. It advances that copy for every
   // accepted request word, and it holds the response words that are still due.
   class timer_shadow;
      logic [11:0] tick_period;
      logic [19:0] div_period;
      logic [7:0]  divider_byte;
      logic [7:0]  count_byte;
      logic [7:0]  modulo_byte;
      logic [7:0]  control_byte;
      int          divider_remaining;
      int          timer_remaining;
      logic [21:0] timer_period;
      bit          timer_enabled;
      bit          irq_pending;
      rsp_type     due_results[$];
      int          errors;

      function new();
         tick_period       = TICK_PERIOD_RESET;
         div_period        = DIV_PERIOD_RESET;
         divider_byte      = '0;
         count_byte        = '0;
         modulo_byte       = '0;
         control_byte      = '0;
         divider_remaining = 0;
         timer_remaining   = 0;
         timer_period      = '0;
         timer_enabled     = 1'b0;
         irq_pending       = 1'b0;
         errors            = 0;
      endfunction

      function void set_config(input logic index, input logic [31:0] value);
         if (index == CSR_TICK_PERIOD) begin
            tick_period = value[11:0];
         end else begin
            div_period = value[19:0];
         end
      endfunction

      // Subtracts the elapsed time and adds at most one period back.
      function int count_down(input int remaining, input int elapsed, input int period,
                              output bit wrapped);
         int r;
         r = remaining - elapsed;
         wrapped = 1'b0;
         if (r < 0) begin
            r += period;
            wrapped = 1'b1;
         end
         if (r < COUNT_FLOOR) r = COUNT_FLOOR;
         if (r > COUNT_CEIL) r = COUNT_CEIL;
         return r;
      endfunction

      function void apply_word(input req_type w);
         rsp_type res;
         bit      wrapped;
         int      shift;
         res = '0;
         case (w.func)
            FUNC_ADVANCE: begin
               if (div_period != 0) begin
                  divider_remaining = count_down(divider_remaining, int'(w.elapsed),
                                                 int'(div_period), wrapped);
                  if (wrapped) divider_byte = divider_byte + 8'd1;
               end
               if (timer_enabled && timer_period != 0) begin
                  timer_remaining = count_down(timer_remaining, int'(w.elapsed),
                                               int'(timer_period), wrapped);
                  if (wrapped) begin
                     if (count_byte == COUNT_WRAP) begin
                        count_byte  = modulo_byte;
                        irq_pending = 1'b1;
                     end else begin
                        count_byte = count_byte + 8'd1;
                     end
                  end
               end
               if (!w.irq_blocked && irq_pending) begin
                  irq_pending     = 1'b0;
                  res.irq_request = 1'b1;
               end
            end
            FUNC_READ: begin
               case (w.reg_sel)
                  REG_DIVIDER: res.read_data = divider_byte;
                  REG_COUNTER: res.read_data = count_byte;
                  REG_MODULO:  res.read_data = modulo_byte;
                  default:     res.read_data = control_byte;
               endcase
            end
            FUNC_WRITE: begin
               case (w.reg_sel)
                  REG_DIVIDER: divider_byte = '0;
                  REG_COUNTER: count_byte = w.write_data;
                  REG_MODULO:  modulo_byte = w.write_data;
                  default: begin
                     case (w.write_data[1:0])
                        2'd0:    shift = 10;
                        2'd1:    shift = 4;
                        2'd2:    shift = 6;
                        default: shift = 8;
                     endcase
                     control_byte  = w.write_data;
                     timer_period  = {10'd0, tick_period} << shift;
                     timer_enabled = w.write_data[CTRL_ENABLE_BIT];
                  end
               endcase
            end
            default: ;
         endcase
         due_results.push_back(res);
      endfunction

      function void compare_result(input rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            $display("%0t: unexpected response, expected none, got read_data=%h irq=%b",
                     $time, got.read_data, got.irq_request);
            errors++;
            return;
         end
         want = due_results.pop_front();
         if (got.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch, expected %h, got %h",
                     $time, want.read_data, got.read_data);
            errors++;
         end
         if (got.irq_request !== want.irq_request) begin
            $display("%0t: irq_request mismatch, expected %b, got %b",
                     $time, want.irq_request, got.irq_request);
            errors++;
         end
      endfunction

      function int due_count();
         return due_results.size();
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   timer_shadow shadow;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          cycles = 0;

   timer_divider_with_reload_irq dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The watchdog stops a hung run. It counts every cycle from time zero.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[timer_divider_with_reload_irq] ERROR");
         $finish;
      end
   end

   // The result side stalls at random. It draws a new ready value every cycle,
   // so the stalls fall on every phase of the block's two-stage pipeline.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Every response word accepted at this edge is checked against the oldest one due.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         shadow.compare_result(rsp_data);
      end
   end

   // The sender may idle before each word. Valid is lowered only during an idle
   // cycle, so a word that follows straight away keeps valid high across the edge.
   task automatic send_word(input req_type w);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      shadow.apply_word(w);
   endtask

   // Holds off the sender until every response that is due has come back.
   // Every word answers, so a short settle afterwards is enough before a register write.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (shadow.due_count() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // This is an APB write with a setup cycle and an access cycle. The register
   // takes the data at the edge that ends the access cycle. The bus then idles,
   // so a write that comes next starts from a clean bus.
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      shadow.set_config(addr[2], value);
      @(posedge clock);
   endtask

   function automatic req_type make_word(input logic [1:0] func, input logic [1:0] sel,
                                         input logic [7:0] data, input logic [15:0] elapsed,
                                         input logic blocked);
      req_type w;
      w.func        = func;
      w.reg_sel     = sel;
      w.write_data  = data;
      w.elapsed     = elapsed;
      w.irq_blocked = blocked;
      return w;
   endfunction

   // Some advances stay within twice the active period, so the counters wrap
   // without drifting; others are zero or tiny, or use the full range to saturate.
   function automatic logic [15:0] pick_elapsed();
      int span;
      int roll;
      span = (shadow.timer_enabled && shadow.timer_period != 0) ?
             int'(shadow.timer_period) * 2 : int'(shadow.div_period) * 2;
      if (span > 65535) span = 65535;
      if (span < 1) span = 1;
      roll = $urandom_range(99);
      if (roll < 10) return 16'h0000;
      if (roll < 20) return 16'hFFFF;
      if (roll < 45) return 16'($urandom_range(15));
      if (roll < 75) return 16'($urandom_range(span));
      return 16'($urandom_range(65535));
   endfunction

   // Counter writes often land just below the wrap value, so that reloads and
   // interrupt requests come often. Control writes mostly enable the timer.
   function automatic req_type random_word();
      req_type w;
      int      roll;
      w    = 29'($urandom);
      roll = $urandom_range(99);
      if (roll < 55) begin
         w.func        = FUNC_ADVANCE;
         w.elapsed     = pick_elapsed();
         w.irq_blocked = ($urandom_range(3) == 0);
      end else if (roll < 75) begin
         w.func = FUNC_READ;
      end else if (roll < 95) begin
         w.func = FUNC_WRITE;
         if (w.reg_sel == REG_COUNTER && $urandom_range(1) == 1) begin
            w.write_data = 8'hF0 | 8'($urandom_range(15));
         end else if (w.reg_sel == REG_CONTROL) begin
            w.write_data[CTRL_ENABLE_BIT] = ($urandom_range(9) < 7);
         end
      end else begin
         w.func = FUNC_UNUSED;
      end
      return w;
   endfunction

   initial begin
      logic [11:0] tick_values [8];
      logic [19:0] div_values [8];

      shadow = new();
      // The settings include both extremes of each register, zero periods that halt
      // the timer and the divider, and tiny periods that saturate the counters.
      tick_values = '{12'd1, 12'd4095, 12'd0, 12'd2, 12'd9, 12'd4095, 12'd1, 12'd0};
      div_values  = '{20'd1, 20'd1048575, 20'd0, 20'd50, 20'd2000, 20'd1, 20'd1048575, 20'd0};
      tick_values[7] = 12'($urandom_range(4095, 1));
      div_values[7]  = 20'($urandom_range(1048575, 1));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // This directed part runs with the reset periods: tick 286 and divider 73216.
      send_word(make_word(FUNC_READ, REG_DIVIDER, 8'h00, 16'h0000, 1'b0));
      send_word(make_word(FUNC_READ, REG_COUNTER, 8'h00, 16'h0000, 1'b0));
      send_word(make_word(FUNC_READ, REG_MODULO, 8'h00, 16'h0000, 1'b0));
      send_word(make_word(FUNC_READ, REG_CONTROL, 8'h00, 16'h0000, 1'b0));
      send_word(make_word(FUNC_WRITE, REG_DIVIDER, 8'hFF, 16'h0000, 1'b0));
      send_word(make_word(FUNC_WRITE, REG_COUNTER, 8'hFE, 16'h0000, 1'b0));
      send_word(make_word(FUNC_WRITE, REG_MODULO, 8'hAB, 16'h0000, 1'b0));
      // The timer is enabled with the 16x rate.
      send_word(make_word(FUNC_WRITE, REG_CONTROL, 8'h05, 16'h0000, 1'b0));
      send_word(make_word(FUNC_READ, REG_CONTROL, 8'h00, 16'h0000, 1'b0));
      send_word(make_word(FUNC_READ, REG_COUNTER, 8'h00, 16'h0000, 1'b0));
      send_word(make_word(FUNC_ADVANCE, REG_DIVIDER, 8'h00, 16'h0000, 1'b0));
      send_word(make_word(FUNC_ADVANCE, REG_DIVIDER, 8'h00, 16'hFFFF, 1'b0));
      // The counter wraps to the modulo value here while the slot is blocked, so the
      // request stays pending until the next advance that is not blocked.
      send_word(make_word(FUNC_ADVANCE, REG_DIVIDER, 8'h00, 16'hFFFF, 1'b1));
      send_word(make_word(FUNC_ADVANCE, REG_DIVIDER, 8'h00, 16'h0001, 1'b1));
      send_word(make_word(FUNC_ADVANCE, REG_DIVIDER, 8'h00, 16'h0001, 1'b0));
      send_word(make_word(FUNC_READ, REG_COUNTER, 8'h00, 16'h0000, 1'b0));
      send_word(make_word(FUNC_READ, REG_DIVIDER, 8'h00, 16'h0000, 1'b0));
      // The unused operation code is sent with every field bit set.
      send_word(make_word(FUNC_UNUSED, 2'b11, 8'hFF, 16'hFFFF, 1'b1));
      send_word(make_word(FUNC_WRITE, REG_CONTROL, 8'h00, 16'h0000, 1'b0));
      send_word(make_word(FUNC_ADVANCE, REG_DIVIDER, 8'h00, 16'hFFFF, 1'b0));
      send_word(make_word(FUNC_WRITE, REG_CONTROL, 8'hFF, 16'h0000, 1'b0));
      send_word(make_word(FUNC_WRITE, REG_COUNTER, 8'hFF, 16'h0000, 1'b0));
      send_word(make_word(FUNC_ADVANCE, REG_DIVIDER, 8'h00, 16'hFFFF, 1'b0));
      send_word(make_word(FUNC_READ, REG_CONTROL, 8'h00, 16'h0000, 1'b0));

      // Each random phase drains the block, writes both periods, and then cycles
      // through the idle patterns: none, a slow sender, a slow receiver, or both.
      for (int phase = 0; phase < 8; phase++) begin
         wait_drained();
         csr_write(ADDR_TICK_PERIOD, {20'd0, tick_values[phase]});
         csr_write(ADDR_DIV_PERIOD, {12'd0, div_values[phase]});
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 70; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 70; end
            default: begin send_idle_pct = 33; rsp_stall_pct = 33; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // In the middle of one phase, the sender holds off until the pipeline is empty.
            if (phase == 3 && n == ITEMS_PER_PHASE / 2) wait_drained();
            send_word(random_word());
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (shadow.errors == 0 && shadow.due_count() == 0) begin
         $display("[timer_divider_with_reload_irq] OK");
      end else begin
         $display("[timer_divider_with_reload_irq] ERROR");
      end
      $finish;
   end

endmodule
